// ----- src/rpn_pkg.sv -----
// Shared types, constants and codes for the reverse Polish evaluator.
// Used by the top level, the controller, the datapath and the divider.
package rpn_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FINAL    = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_FEW      = 3'd3,
        ST_BAD_OP   = 3'd4,
        ST_DIV_ZERO = 3'd5,
        ST_LEFTOVER = 3'd6,
        ST_OVERFLOW = 3'd7
    } t_status;

    typedef struct packed {
        logic load_tok;
        logic eval;
        logic exec;
        logic div_start;
        logic div_load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_ops;
        logic is_div;
        logic div_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- src/rpn_tok_if.sv -----
// Token channel: valid/ready handshake with the one-character token payload.
// Depends on nothing.
interface rpn_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_byte;
    logic       token_too_long;
    logic       last_token;

    modport source (output valid, output token_byte, output token_too_long,
                    output last_token, input ready);
    modport sink   (input valid, input token_byte, input token_too_long,
                    input last_token, output ready);
endinterface

// ----- src/rpn_res_if.sv -----
// Result channel: valid/ready handshake with value and status payload.
// Depends on nothing.
interface rpn_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- src/rpn_stack_evaluator_unit.sv -----
// Top level of the reverse Polish evaluator: controller, datapath, channel wiring.
// Depends on rpn_pkg, rpn_tok_if, rpn_res_if, rpn_ctrl and rpn_dp.
//
// Usage:
//   i_tok carries one token per transaction: token_byte, token_too_long and
//   last_token. A digit pushes its value; + - * / pop two operands and push
//   bottom op top, wrapping, division truncating toward zero.
//   o_res returns exactly one transaction per token: status, and on the final
//   token of a well-formed expression the value with status 1.
//   Each token passes accept, classify (EVAL), execute (EXEC) and commit
//   (DONE) before its result is registered; a division adds the radix-2 divider
//   (one quotient bit per cycle over 32 bits) between execute and commit.
//   One token is in flight at a time and a new token is taken the cycle after
//   the previous result is loaded.
//   The result register holds its transaction while o_res.ready is low; the
//   next token is still accepted and computed, then waits until the result
//   register frees up.
//   Reset (i_rst_n low, synchronous) empties the stack and drops any pending
//   result; the stack memory itself is not cleared. An error or the end of
//   an expression empties the stack.
module rpn_stack_evaluator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rpn_tok_if.sink      i_tok,
    rpn_res_if.source    o_res
);
    rpn_pkg::t_cmd w_cmd;
    rpn_pkg::t_sts w_sts;

    rpn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .o_tok_ready (i_tok.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rpn_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_token_byte     (i_tok.token_byte),
        .i_token_too_long (i_tok.token_too_long),
        .i_last_token     (i_tok.last_token),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_value          (o_res.value),
        .o_status         (o_res.status)
    );
endmodule

// ----- src/rpn_div.sv -----
// Iterative restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on rpn_pkg.
module rpn_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rpn_pkg::DATA_W-1:0]   i_num,
    input  logic [rpn_pkg::DATA_W-1:0]   i_den,
    output logic                         o_done,
    output logic [rpn_pkg::DATA_W-1:0]   o_quo
);
    localparam int W = rpn_pkg::DATA_W;

    logic                                r_busy, n_busy;
    logic                                r_done, n_done;
    logic [rpn_pkg::DIV_CNT_W-1:0]       r_cnt, n_cnt;
    logic [W-1:0]                        r_rem, n_rem;
    logic [W-1:0]                        r_quo, n_quo;
    logic [W-1:0]                        r_den, n_den;
    logic [W:0]                          w_shift;
    logic [W:0]                          w_diff;
    logic                                w_ge;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = rpn_pkg::DIV_CNT_W'(W);
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
            n_quo = {r_quo[W-2:0], w_ge};
            n_cnt = r_cnt - rpn_pkg::DIV_CNT_W'(1);
            if (r_cnt == rpn_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ----- src/rpn_dp.sv -----
// Datapath: token register, operand stack memory, ALU, divider and result register.
// Depends on rpn_pkg and rpn_div.
module rpn_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpn_pkg::t_cmd        i_cmd,
    output rpn_pkg::t_sts        o_sts,
    input  logic [7:0]           i_token_byte,
    input  logic                 i_token_too_long,
    input  logic                 i_last_token,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [31:0]   o_value,
    output logic [2:0]           o_status
);
    localparam int W  = rpn_pkg::DATA_W;
    localparam int CW = rpn_pkg::CNT_W;
    localparam int AW = rpn_pkg::ADDR_W;

    logic [W-1:0]      r_mem [rpn_pkg::STACK_DEPTH];
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [7:0]        r_byte;
    logic              r_too_long;
    logic              r_last;
    logic              r_is_op;
    logic              r_is_div;
    logic              r_need_ops;
    rpn_pkg::t_status  r_code;
    logic [W-1:0]      r_res;
    logic [W-1:0]      r_top, r_bot;
    logic              r_out_valid;
    logic [W-1:0]      r_value;
    rpn_pkg::t_status  r_status;

    logic              w_digit, w_known_op, w_full, w_few;
    logic [CW-1:0]     w_cnt_m1, w_cnt_m2, w_cnt_after;
    logic [AW-1:0]     w_wr_addr;
    logic              w_neg, w_div_zero, w_out_free;
    logic [W-1:0]      w_num_mag, w_den_mag, w_quo;
    logic              w_div_done;
    logic [W-1:0]      w_fin_value;
    rpn_pkg::t_status  w_fin_status;

    assign w_digit    = (r_byte >= rpn_pkg::CH_ZERO) && (r_byte <= rpn_pkg::CH_NINE);
    assign w_known_op = (r_byte == rpn_pkg::CH_PLUS) || (r_byte == rpn_pkg::CH_MINUS)
                     || (r_byte == rpn_pkg::CH_STAR) || (r_byte == rpn_pkg::CH_SLASH);
    assign w_full     = r_cnt >= CW'(rpn_pkg::STACK_DEPTH);
    assign w_few      = r_cnt < CW'(2);
    assign w_cnt_m1   = r_cnt - CW'(1);
    assign w_cnt_m2   = r_cnt - CW'(2);
    assign w_cnt_after = r_is_op ? w_cnt_m1 : r_cnt + CW'(1);
    assign w_wr_addr  = r_is_op ? w_cnt_m2[AW-1:0] : r_cnt[AW-1:0];

    assign w_neg      = r_bot[W-1] ^ r_top[W-1];
    assign w_div_zero = r_top == '0;
    assign w_num_mag  = r_bot[W-1] ? W'(0) - r_bot : r_bot;
    assign w_den_mag  = r_top[W-1] ? W'(0) - r_top : r_top;
    assign w_out_free = !r_out_valid || i_out_ready;

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num_mag),
        .i_den   (w_den_mag),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_cnt        = r_cnt;
        w_fin_value  = '0;
        w_fin_status = r_code;
        if (r_code == rpn_pkg::ST_OK) begin
            if (r_last) begin
                n_cnt = '0;
                if (w_cnt_after == CW'(1)) begin
                    w_fin_status = rpn_pkg::ST_FINAL;
                    w_fin_value  = r_res;
                end else begin
                    w_fin_status = rpn_pkg::ST_LEFTOVER;
                end
            end else begin
                n_cnt = w_cnt_after;
            end
        end else begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tok) begin
            r_byte     <= i_token_byte;
            r_too_long <= i_token_too_long;
            r_last     <= i_last_token;
        end
        if (i_cmd.eval) begin
            r_is_op    <= !w_digit;
            r_is_div   <= r_byte == rpn_pkg::CH_SLASH;
            r_need_ops <= 1'b0;
            r_res      <= {{(W-8){1'b0}}, r_byte - rpn_pkg::CH_ZERO};
            r_top      <= r_mem[w_cnt_m1[AW-1:0]];
            r_bot      <= r_mem[w_cnt_m2[AW-1:0]];
            if (r_too_long) begin
                r_code <= rpn_pkg::ST_TOO_LONG;
            end else if (w_digit) begin
                r_code <= w_full ? rpn_pkg::ST_OVERFLOW : rpn_pkg::ST_OK;
            end else if (w_few) begin
                r_code <= rpn_pkg::ST_FEW;
            end else if (!w_known_op) begin
                r_code <= rpn_pkg::ST_BAD_OP;
            end else begin
                r_code     <= rpn_pkg::ST_OK;
                r_need_ops <= 1'b1;
            end
        end
        if (i_cmd.exec) begin
            case (r_byte)
                rpn_pkg::CH_PLUS:  r_res <= r_bot + r_top;
                rpn_pkg::CH_MINUS: r_res <= r_bot - r_top;
                rpn_pkg::CH_STAR:  r_res <= W'(r_bot * r_top);
                default: begin
                    if (w_div_zero) begin
                        r_code <= rpn_pkg::ST_DIV_ZERO;
                    end
                end
            endcase
        end
        if (i_cmd.div_load) begin
            r_res <= w_neg ? W'(0) - w_quo : w_quo;
        end
        if (i_cmd.commit) begin
            if (r_code == rpn_pkg::ST_OK) begin
                r_mem[w_wr_addr] <= r_res;
            end
            r_value  <= w_fin_value;
            r_status <= w_fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_cnt <= n_cnt;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.need_ops = r_need_ops;
    assign o_sts.is_div   = r_is_div;
    assign o_sts.div_zero = w_div_zero;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;
endmodule

// ----- src/rpn_ctrl.sv -----
// Controller: sequences accept, classify, operand read, execute, divide and commit.
// Depends on rpn_pkg.
module rpn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    output logic           o_tok_ready,
    input  rpn_pkg::t_sts  i_sts,
    output rpn_pkg::t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_EXEC = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_tok_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_tok_ready = 1'b1;
                if (i_tok_valid) begin
                    o_cmd.load_tok = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.need_ops) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.exec = 1'b1;
                    if (i_sts.is_div && !i_sts.div_zero) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for rpn_stack_evaluator_unit: token driver, result monitor and predictor.
// Depends on rpn_stack_evaluator_unit, rpn_pkg, rpn_tok_if and rpn_res_if from the RTL sources.
// Directed tokens run first, then random expressions with broken and noisy tokens.
module testbench;

    typedef struct {
        logic [7:0] ch;
        logic       too_long;
        logic       is_last;
        logic       wait_drain;
    } t_rpn_token;

    typedef struct {
        logic signed [31:0] value;
        rpn_pkg::t_status   status;
    } t_rpn_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rpn_tok_if tok ();
    rpn_res_if res ();

    rpn_stack_evaluator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok),
        .o_res   (res)
    );

    t_rpn_token   token_queue[$];
    t_rpn_outcome expected_outcomes[$];
    logic [31:0]  model_stack [rpn_pkg::STACK_DEPTH];
    int unsigned  model_depth = 0;

    logic tok_taken  = 1'b0;
    logic allow_idle = 1'b0;
    int   calm_left  = 0;
    int   send_gap   = 0;
    int   stall_left = 0;

    int mismatch_count  = 0;
    int tokens_accepted = 0;
    int results_checked = 0;
    int finals_seen     = 0;
    int errors_seen     = 0;

    always #6 i_clk = ~i_clk;

    function automatic t_rpn_outcome evaluate_token_outcome(input logic [7:0] ch,
                                                            input logic too_long,
                                                            input logic is_last);
        t_rpn_outcome     r;
        rpn_pkg::t_status st;
        logic [31:0]      top_v;
        logic [31:0]      bot_v;
        logic [31:0]      acc;
        logic [31:0]      mag_b;
        logic [31:0]      mag_t;
        logic [31:0]      quo;
        r.value = '0;
        st      = rpn_pkg::ST_OK;
        acc     = '0;
        if (too_long) begin
            st = rpn_pkg::ST_TOO_LONG;
        end else if (ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE) begin
            if (model_depth >= rpn_pkg::STACK_DEPTH) begin
                st = rpn_pkg::ST_OVERFLOW;
            end else begin
                model_stack[model_depth] = {24'd0, ch - rpn_pkg::CH_ZERO};
                model_depth++;
            end
        end else if (model_depth < 2) begin
            st = rpn_pkg::ST_FEW;
        end else begin
            top_v = model_stack[model_depth - 1];
            bot_v = model_stack[model_depth - 2];
            case (ch)
                rpn_pkg::CH_PLUS:  acc = bot_v + top_v;
                rpn_pkg::CH_MINUS: acc = bot_v - top_v;
                rpn_pkg::CH_STAR:  acc = bot_v * top_v;
                rpn_pkg::CH_SLASH: begin
                    if (top_v == 32'd0) begin
                        st = rpn_pkg::ST_DIV_ZERO;
                    end else begin
                        mag_b = bot_v[31] ? (~bot_v + 32'd1) : bot_v;
                        mag_t = top_v[31] ? (~top_v + 32'd1) : top_v;
                        quo   = mag_b / mag_t;
                        acc   = (bot_v[31] ^ top_v[31]) ? (~quo + 32'd1) : quo;
                    end
                end
                default:  st = rpn_pkg::ST_BAD_OP;
            endcase
            if (st == rpn_pkg::ST_OK) begin
                model_depth--;
                model_stack[model_depth - 1] = acc;
            end
        end
        if (st != rpn_pkg::ST_OK) begin
            model_depth = 0;
        end else if (is_last) begin
            if (model_depth == 1) begin
                r.value = model_stack[0];
                st      = rpn_pkg::ST_FINAL;
            end else begin
                st = rpn_pkg::ST_LEFTOVER;
            end
            model_depth = 0;
        end
        r.status = st;
        return r;
    endfunction

    function automatic void queue_token(input logic [7:0] ch, input logic too_long,
                                        input logic is_last);
        t_rpn_token t;
        t.ch         = ch;
        t.too_long   = too_long;
        t.is_last    = is_last;
        t.wait_drain = 1'b0;
        token_queue.push_back(t);
    endfunction

    function automatic void queue_digit(input int unsigned d, input logic is_last);
        queue_token(rpn_pkg::CH_ZERO + 8'(d), 1'b0, is_last);
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return rpn_pkg::CH_PLUS;
            1:       return rpn_pkg::CH_MINUS;
            4:       return rpn_pkg::CH_SLASH;
            default: return rpn_pkg::CH_STAR;
        endcase
    endfunction

    function automatic void queue_expression(input int n_ops, input int push_pct);
        int d;
        int digits_left;
        d           = 0;
        digits_left = n_ops + 1;
        while (digits_left > 0 || d > 1) begin
            if (d < 2 || (digits_left > 0 && d < rpn_pkg::STACK_DEPTH &&
                          $urandom_range(0, 99) < push_pct)) begin
                digits_left--;
                d++;
                queue_digit($urandom_range(0, 9), digits_left == 0 && d == 1);
            end else begin
                d--;
                queue_token(random_operator(), 1'b0, digits_left == 0 && d == 1);
            end
        end
    endfunction

    function automatic void queue_overflow();
        repeat (rpn_pkg::STACK_DEPTH) queue_digit($urandom_range(0, 9), 1'b0);
        queue_digit($urandom_range(0, 9), 1'($urandom_range(0, 1)));
    endfunction

    // 2^31 wraps to the most negative value, then divide it by -1
    function automatic void queue_most_negative();
        queue_digit(2, 1'b0);
        repeat (30) begin
            queue_digit(2, 1'b0);
            queue_token(rpn_pkg::CH_STAR, 1'b0, 1'b0);
        end
        queue_digit(0, 1'b0);
        queue_digit(1, 1'b0);
        queue_token(rpn_pkg::CH_MINUS, 1'b0, 1'b0);
        queue_token(rpn_pkg::CH_SLASH, 1'b0, 1'b1);
    endfunction

    always @(posedge i_clk) begin : idle_control
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(0, 199) == 0) begin
            calm_left <= $urandom_range(30, 120);
        end
        allow_idle <= (token_queue.size() > 150) && (calm_left == 0);
    end

    always @(negedge i_clk) begin : token_driver
        t_rpn_token nxt;
        if (!i_rst_n) begin
            tok.valid <= 1'b0;
        end else if (!tok.valid || tok_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                tok.valid <= 1'b0;
            end else if (token_queue.size() == 0 ||
                         (token_queue[0].wait_drain && expected_outcomes.size() != 0)) begin
                tok.valid <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(0, 2);
                tok.valid <= 1'b0;
            end else begin
                nxt = token_queue.pop_front();
                tok.valid          <= 1'b1;
                tok.token_byte     <= nxt.ch;
                tok.token_too_long <= nxt.too_long;
                tok.last_token     <= nxt.is_last;
            end
        end
    end

    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            res.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_rpn_outcome want;
        if (!i_rst_n) begin
            tok_taken <= 1'b0;
        end else begin
            tok_taken <= tok.valid && tok.ready;
            if (tok.valid && tok.ready) begin
                tokens_accepted++;
                expected_outcomes.push_back(evaluate_token_outcome(tok.token_byte,
                                                                   tok.token_too_long,
                                                                   tok.last_token));
            end
            if (res.valid && res.ready) begin
                results_checked++;
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result: status %0d value %0d", res.status, res.value);
                    mismatch_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (res.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, res.status);
                        mismatch_count++;
                    end
                    if (res.value !== want.value) begin
                        $error("value mismatch: expected %0d, actual %0d",
                               want.value, res.value);
                        mismatch_count++;
                    end
                    if (want.status == rpn_pkg::ST_FINAL) begin
                        finals_seen++;
                    end else if (want.status != rpn_pkg::ST_OK) begin
                        errors_seen++;
                    end
                end
            end
        end
    end

    initial begin : timeout_guard
        #6000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int base;
        int idx;
        i_rst_n <= 1'b0;

        // single digit, minus, times and divide, truncating division of a negative
        queue_digit(9, 1'b1);
        queue_digit(7, 1'b0); queue_digit(2, 1'b0);
        queue_token(rpn_pkg::CH_MINUS, 1'b0, 1'b1);
        queue_digit(3, 1'b0); queue_digit(4, 1'b0);
        queue_token(rpn_pkg::CH_STAR, 1'b0, 1'b1);
        queue_digit(9, 1'b0); queue_digit(2, 1'b0);
        queue_token(rpn_pkg::CH_SLASH, 1'b0, 1'b1);
        queue_digit(2, 1'b0); queue_digit(9, 1'b0);
        queue_token(rpn_pkg::CH_MINUS, 1'b0, 1'b0);
        queue_digit(2, 1'b0); queue_token(rpn_pkg::CH_SLASH, 1'b0, 1'b1);
        // error statuses
        queue_digit(1, 1'b0); queue_digit(0, 1'b0);
        queue_token(rpn_pkg::CH_SLASH, 1'b0, 1'b0);
        queue_digit(1, 1'b0); queue_token(8'hFF, 1'b0, 1'b0);
        queue_digit(1, 1'b0); queue_digit(2, 1'b0); queue_token(8'h00, 1'b0, 1'b0);
        queue_token(rpn_pkg::CH_ZERO + 8'd5, 1'b1, 1'b0);
        queue_digit(1, 1'b0); queue_digit(2, 1'b1);
        queue_token(rpn_pkg::CH_PLUS, 1'b0, 1'b1);

        base = token_queue.size();
        queue_overflow();
        token_queue[base].wait_drain = 1'b1;
        queue_most_negative();

        while (token_queue.size() < 1600) begin
            kind = $urandom_range(0, 99);
            base = token_queue.size();
            if (kind < 65) begin
                queue_expression($urandom_range(1, 6), 50);
            end else if (kind < 77) begin
                queue_expression($urandom_range(1, 6), 50);
                idx = $urandom_range(base, token_queue.size() - 1);
                case ($urandom_range(0, 3))
                    0:       token_queue[idx].too_long = 1'b1;
                    1:       token_queue[idx].ch = 8'($urandom_range(0, 255));
                    2:       token_queue[idx].is_last = ~token_queue[idx].is_last;
                    default: token_queue[token_queue.size() - 1].is_last = 1'b0;
                endcase
            end else if (kind < 87) begin
                repeat ($urandom_range(1, 4)) begin
                    queue_token(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 2) == 0);
                end
            end else if (kind < 94) begin
                queue_expression($urandom_range(20, 31), 95);
            end else if (kind < 97) begin
                queue_overflow();
            end else begin
                queue_most_negative();
            end
            if ($urandom_range(0, 39) == 0) begin
                token_queue[base].wait_drain = 1'b1;
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (token_queue.size() != 0 || tok.valid || expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d tokens, %0d results checked: %0d final values, %0d errors",
                 tokens_accepted, results_checked, finals_seen, errors_seen);
        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
